### design/inverter_switch_pattern_control_unit_assert.svh
`ifndef INVERTER_SWITCH_PATTERN_CONTROL_UNIT_ASSERT_SVH
`define INVERTER_SWITCH_PATTERN_CONTROL_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define ISPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ISPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/ispc_pkg.sv
package ispc_pkg;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  typedef struct packed {
    logic       req_type;
    logic       charger_ok;
    logic [9:0] solar_level;
    logic       mains_present;
  } tick_t;

  typedef struct packed {
    logic       inverter_on;
    logic [1:0] bridge_drive;
  } result_t;

  typedef struct packed {
    logic [1:0] backup_mode;
    logic [7:0] dark_threshold;
  } mode_cfg_t;

  localparam logic [CFG_IDX_W-1:0] REG_WAVE_PATTERN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKUP_MODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 2'd2;

  localparam logic [1:0] MODE_DARK_NO_MAINS = 2'd0;
  localparam logic [1:0] MODE_NO_MAINS      = 2'd1;

  localparam logic [1:0] DRIVE_OFF = 2'd0;
  localparam logic [1:0] DRIVE_POS = 2'd1;
  localparam logic [1:0] DRIVE_NEG = 2'd2;

  localparam logic REQ_CONTROL = 1'b0;

  localparam logic [2:0] DEBOUNCE_START = 3'd3;
  localparam logic [2:0] DEBOUNCE_ON    = 3'd6;
  localparam logic [2:0] DEBOUNCE_OFF   = 3'd0;

endpackage

### design/ispc_chan_if.sv
interface ispc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/ispc_cfg_regs.sv
module ispc_cfg_regs #(
  parameter int PATTERN_STEPS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ispc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ispc_pkg::CFG_W-1:0]        cfg_data,
  output logic [PATTERN_STEPS-1:0]          wave_pattern,
  output ispc_pkg::mode_cfg_t               mode_cfg
);
  import ispc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_pattern            <= '0;
      mode_cfg.backup_mode    <= MODE_NO_MAINS;
      mode_cfg.dark_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAVE_PATTERN:   wave_pattern <= cfg_data[PATTERN_STEPS-1:0];
        REG_BACKUP_MODE:    mode_cfg.backup_mode <= cfg_data[1:0];
        REG_DARK_THRESHOLD: mode_cfg.dark_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end
endmodule

### design/ispc_core.sv
module ispc_core #(
  parameter int PATTERN_STEPS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  ispc_pkg::tick_t          tick_q,
  input  logic [PATTERN_STEPS-1:0] wave_pattern,
  input  ispc_pkg::mode_cfg_t      mode_cfg,
  output ispc_pkg::result_t        result_next
);
  import ispc_pkg::*;

  localparam int STEP_W = $clog2(PATTERN_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PATTERN_STEPS - 1);

  logic [STEP_W-1:0] step_index, step_index_next;
  logic              negative_half, negative_half_next;
  logic [2:0]        debounce_count, debounce_count_next;
  logic              running, running_next;
  logic [1:0]        last_drive, last_drive_next;

  logic       dark;
  logic       cond;
  logic [2:0] count_step;

  assign dark = tick_q.solar_level < 10'(mode_cfg.dark_threshold);

  always_comb begin
    case (mode_cfg.backup_mode)
      MODE_DARK_NO_MAINS: cond = dark && !tick_q.mains_present;
      MODE_NO_MAINS:      cond = !tick_q.mains_present;
      default:            cond = dark;
    endcase
  end

  assign count_step = cond ? debounce_count + 3'd1 : debounce_count - 3'd1;

  always_comb begin
    step_index_next     = step_index;
    negative_half_next  = negative_half;
    debounce_count_next = debounce_count;
    running_next        = running;
    last_drive_next     = last_drive;
    if (tick_q.req_type == REQ_CONTROL) begin
      if (tick_q.charger_ok) begin
        if (count_step >= DEBOUNCE_ON) begin
          running_next        = 1'b1;
          debounce_count_next = DEBOUNCE_START;
        end else if (count_step == DEBOUNCE_OFF) begin
          running_next        = 1'b0;
          debounce_count_next = DEBOUNCE_START;
        end else begin
          debounce_count_next = count_step;
        end
      end else begin
        running_next = 1'b0;
      end
      if (!running_next) begin
        last_drive_next = DRIVE_OFF;
      end
    end else begin
      if (!running) begin
        step_index_next = '0;
        last_drive_next = DRIVE_OFF;
      end else begin
        if (wave_pattern[step_index]) begin
          last_drive_next = DRIVE_OFF;
        end else begin
          last_drive_next = negative_half ? DRIVE_NEG : DRIVE_POS;
        end
        if (step_index >= LAST_STEP) begin
          step_index_next    = '0;
          negative_half_next = !negative_half;
        end else begin
          step_index_next = step_index + 1'b1;
        end
      end
    end
  end

  assign result_next.inverter_on  = running_next;
  assign result_next.bridge_drive = last_drive_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index     <= '0;
      negative_half  <= 1'b0;
      debounce_count <= DEBOUNCE_START;
      running        <= 1'b0;
      last_drive     <= DRIVE_OFF;
    end else if (fire) begin
      step_index     <= step_index_next;
      negative_half  <= negative_half_next;
      debounce_count <= debounce_count_next;
      running        <= running_next;
      last_drive     <= last_drive_next;
    end
  end
endmodule

### design/inverter_switch_pattern_control_unit.sv
// channel   direction  payload
// tick      sink       req_type, charger_ok, solar_level, mains_present
// result    source     inverter_on, bridge_drive
//
// one tick per cycle sustained while each result is taken; a tick transaction goes
// first into the tick register and then, through the state update, into the result
// register, where its result is valid until it is taken
// rst is synchronous: state, valid flags and configuration return to defaults
// a stalled result holds; a held tick waits in the tick register, so one more
// transaction is taken while the result waits
`include "inverter_switch_pattern_control_unit_assert.svh"

module inverter_switch_pattern_control_unit #(
  parameter int PATTERN_STEPS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  ispc_chan_if.sink                      tick,
  ispc_chan_if.source                    result,
  input  logic                           cfg_we,
  input  logic [ispc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ispc_pkg::CFG_W-1:0]     cfg_data
);
  import ispc_pkg::*;

  logic [PATTERN_STEPS-1:0] wave_pattern;
  mode_cfg_t                mode_cfg;

  tick_t   tick_q;
  logic    tick_q_valid;
  result_t result_q;
  logic    result_valid;
  result_t result_next;
  logic    advance;
  logic    fire;
  logic    drive_when_off;

  ispc_cfg_regs #(
    .PATTERN_STEPS(PATTERN_STEPS)
  ) u_cfg_regs (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .wave_pattern (wave_pattern),
    .mode_cfg     (mode_cfg)
  );

  ispc_core #(
    .PATTERN_STEPS(PATTERN_STEPS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .tick_q       (tick_q),
    .wave_pattern (wave_pattern),
    .mode_cfg     (mode_cfg),
    .result_next  (result_next)
  );

  assign advance        = !result_valid || result.ready;
  assign fire           = tick_q_valid && advance;
  assign tick.ready     = !tick_q_valid || advance;
  assign result.valid   = result_valid;
  assign result.payload = result_q;

  assign drive_when_off = !result_q.inverter_on && (result_q.bridge_drive != DRIVE_OFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_q_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (tick.ready) begin
        tick_q_valid <= tick.valid;
      end
      if (advance) begin
        result_valid <= tick_q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      tick_q <= tick.payload;
    end
    if (fire) begin
      result_q <= result_next;
    end
  end

  `ISPC_ASSERT_NOW(a_off_no_drive, result_valid, !drive_when_off, "bridge driven while off")
  `ISPC_ASSERT_NOW(a_drive_legal, result_valid, result_q.bridge_drive <= DRIVE_NEG, "bad drive")
  `ISPC_ASSERT_NEXT(a_tick_kept, tick_q_valid && !advance, tick_q_valid, "held tick lost")
  `ISPC_ASSERT_NEXT(a_fire_result, fire, result_valid, "processed tick gave no result")
endmodule
